// File: sv/ukmm_pkg.sv
// Shared types and constants for the unique key min/max table.
`timescale 1ns / 1ps
`default_nettype none
package ukmm_pkg;

   localparam int OP_W       = 2;
   localparam int WEIGHT_W   = 20;
   localparam int COST_W     = 20;
   localparam int STATUS_W   = 3;
   localparam int SUM_W      = 28;
   localparam int TOTAL_W    = 9;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_MAX = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_MIN = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_DECIDE,
      S_WREAD,
      S_REMOVE,
      S_DONE
   } state_type;

   // sequencer to scan unit
   typedef struct packed {
      logic start;
      logic sample;
      logic insert_mode;
      logic max_mode;
   } scan_ctl_type;

   // scan unit findings
   typedef struct packed {
      logic dup;
      logic free_found;
      logic best_found;
   } scan_flags_type;

   // sequencer to accumulator
   typedef struct packed {
      logic add;
      logic sub;
   } acc_ctl_type;

endpackage
`default_nettype wire

// File: sv/ukmm_scan_unit.sv
// Shared compare unit that walks the slots for a duplicate, a free slot or the extreme cost.
`timescale 1ns / 1ps
`default_nettype none
module ukmm_scan_unit #(
   parameter int AW = 8
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire ukmm_pkg::scan_ctl_type     ctl,
   input  wire [AW-1:0]                    idx,
   input  wire                             tag_valid,
   input  wire [ukmm_pkg::COST_W-1:0]      tag_cost,
   input  wire [ukmm_pkg::COST_W-1:0]      key_cost,
   output ukmm_pkg::scan_flags_type        flags,
   output logic [AW-1:0]                   free_idx,
   output logic [AW-1:0]                   best_idx,
   output logic [ukmm_pkg::COST_W-1:0]     best_cost
);

   ukmm_pkg::scan_flags_type       flags_ff, flags_in;
   logic [AW-1:0]                  free_idx_ff, free_idx_in;
   logic [AW-1:0]                  best_idx_ff, best_idx_in;
   logic [ukmm_pkg::COST_W-1:0]    best_cost_ff, best_cost_in;
   logic [ukmm_pkg::COST_W-1:0]    cmp_ref;
   logic                           cmp_gt;
   logic                           cmp_eq;
   logic                           better;

   // one comparator: against the key on insert, against the best so far on remove
   always_comb begin
      cmp_ref = ctl.insert_mode ? key_cost : best_cost_ff;
      cmp_gt  = tag_cost > cmp_ref;
      cmp_eq  = tag_cost == cmp_ref;
      better  = !flags_ff.best_found || (ctl.max_mode ? cmp_gt : (!cmp_gt && !cmp_eq));
   end

   // tracker update per sampled slot
   always_comb begin
      flags_in     = flags_ff;
      free_idx_in  = free_idx_ff;
      best_idx_in  = best_idx_ff;
      best_cost_in = best_cost_ff;
      if (ctl.start) begin
         flags_in = '0;
      end else if (ctl.sample) begin
         if (ctl.insert_mode) begin
            if (tag_valid && cmp_eq) begin
               flags_in.dup = 1'b1;
            end
            if (!tag_valid && !flags_ff.free_found) begin
               flags_in.free_found = 1'b1;
               free_idx_in         = idx;
            end
         end else if (tag_valid && better) begin
            flags_in.best_found = 1'b1;
            best_idx_in         = idx;
            best_cost_in        = tag_cost;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_cost_ff <= best_cost_in;
   end

   assign flags     = flags_ff;
   assign free_idx  = free_idx_ff;
   assign best_idx  = best_idx_ff;
   assign best_cost = best_cost_ff;

endmodule
`default_nettype wire

// File: sv/ukmm_accum.sv
// Running weight sum, cost sum and entry count.
`timescale 1ns / 1ps
`default_nettype none
module ukmm_accum #(
   parameter int CW = 9
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire ukmm_pkg::acc_ctl_type    ctl,
   input  wire [ukmm_pkg::WEIGHT_W-1:0]  weight,
   input  wire [ukmm_pkg::COST_W-1:0]    cost,
   output logic [ukmm_pkg::SUM_W-1:0]    weight_sum,
   output logic [ukmm_pkg::SUM_W-1:0]    cost_sum,
   output logic [CW-1:0]                 count
);

   logic [ukmm_pkg::SUM_W-1:0] wsum_ff, wsum_in;
   logic [ukmm_pkg::SUM_W-1:0] csum_ff, csum_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [ukmm_pkg::SUM_W-1:0] w_ext;
   logic [ukmm_pkg::SUM_W-1:0] c_ext;

   // add or subtract through the same adders, wrapping at the sum width
   always_comb begin
      w_ext    = ukmm_pkg::SUM_W'(weight);
      c_ext    = ukmm_pkg::SUM_W'(cost);
      wsum_in  = wsum_ff;
      csum_in  = csum_ff;
      count_in = count_ff;
      if (ctl.add || ctl.sub) begin
         wsum_in  = wsum_ff + (ctl.sub ? ~w_ext : w_ext) + ukmm_pkg::SUM_W'(ctl.sub);
         csum_in  = csum_ff + (ctl.sub ? ~c_ext : c_ext) + ukmm_pkg::SUM_W'(ctl.sub);
         count_in = ctl.sub ? count_ff - CW'(1) : count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff  <= '0;
         csum_ff  <= '0;
         count_ff <= '0;
      end else begin
         wsum_ff  <= wsum_in;
         csum_ff  <= csum_in;
         count_ff <= count_in;
      end
   end

   assign weight_sum = wsum_ff;
   assign cost_sum   = csum_ff;
   assign count      = count_ff;

endmodule
`default_nettype wire

// File: sv/unique_key_minmax_table.sv
// Top level of the unique key min/max table: sequencer, slot memories and stream ports.
`timescale 1ns / 1ps
`default_nettype none
// A table of DEPTH entries, each a weight and a unique cost, driven by insert,
// remove-highest-cost and remove-lowest-cost items; every item returns one result
// with a status and the running weight sum, cost sum and entry count. After reset
// the block clears every slot tag and takes no item until that is done. Each
// item walks every slot once through one shared comparator reading the tag memory one
// slot a cycle; a remove that finds an entry then reads the weight memory and then
// clears the slot. The next item is taken while a result still waits on the output
// register.
module unique_key_minmax_table #(
   parameter int DEPTH = 256
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // fields from bit 0: operation[1:0], weight[21:2], cost[41:22], zero fill
   input  wire [ukmm_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // fields from bit 0: status[2:0], total_weight[30:3], total_cost[58:31],
   // entry_total[67:59], zero fill
   output logic [ukmm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int TAG_W = ukmm_pkg::COST_W + 1;

   ukmm_pkg::state_type            state_ff, state_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [ukmm_pkg::OP_W-1:0]      op_ff;
   logic [ukmm_pkg::WEIGHT_W-1:0]  weight_ff;
   logic [ukmm_pkg::COST_W-1:0]    cost_ff;
   logic [ukmm_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                           status_load;

   // slot memories: tag is {valid, cost}
   logic [TAG_W-1:0]               tag_mem [DEPTH];
   logic [ukmm_pkg::WEIGHT_W-1:0]  weight_mem [DEPTH];
   logic [TAG_W-1:0]               tag_rd_ff;
   logic [ukmm_pkg::WEIGHT_W-1:0]  weight_rd_ff;
   logic                           rd_vld_ff;
   logic [AW-1:0]                  rd_idx_ff;

   logic                           tag_we;
   logic [AW-1:0]                  tag_waddr;
   logic [TAG_W-1:0]               tag_wdata;
   logic                           tag_re;
   logic                           weight_we;
   logic                           weight_re;

   logic                           accept;
   logic                           rsp_load;
   logic                           rsp_tvalid_ff;
   logic [ukmm_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                           is_insert;

   ukmm_pkg::scan_ctl_type         scan_ctl;
   ukmm_pkg::scan_flags_type       scan_flags;
   logic [AW-1:0]                  free_idx;
   logic [AW-1:0]                  best_idx;
   logic [ukmm_pkg::COST_W-1:0]    best_cost;

   ukmm_pkg::acc_ctl_type          acc_ctl;
   logic [ukmm_pkg::WEIGHT_W-1:0]  acc_weight;
   logic [ukmm_pkg::COST_W-1:0]    acc_cost;
   logic [ukmm_pkg::SUM_W-1:0]     weight_sum;
   logic [ukmm_pkg::SUM_W-1:0]     cost_sum;
   logic [CW-1:0]                  count;

   assign accept    = req_tvalid && req_tready;
   assign is_insert = op_ff == ukmm_pkg::OP_INSERT;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ukmm_pkg::S_CLEAR: begin
            if (cnt_ff == CW'(DEPTH - 1)) state_in = ukmm_pkg::S_IDLE;
         end
         ukmm_pkg::S_IDLE: begin
            if (req_tvalid) state_in = ukmm_pkg::S_SCAN;
         end
         ukmm_pkg::S_SCAN: begin
            if (cnt_ff == CW'(DEPTH - 1)) state_in = ukmm_pkg::S_LAST;
         end
         ukmm_pkg::S_LAST: begin
            state_in = ukmm_pkg::S_DECIDE;
         end
         ukmm_pkg::S_DECIDE: begin
            if (!is_insert && op_ff != ukmm_pkg::OP_REMOVE_MAX
                && op_ff != ukmm_pkg::OP_REMOVE_MIN) begin
               state_in = ukmm_pkg::S_DONE;
            end else if (!is_insert && scan_flags.best_found) begin
               state_in = ukmm_pkg::S_WREAD;
            end else begin
               state_in = ukmm_pkg::S_DONE;
            end
         end
         ukmm_pkg::S_WREAD: begin
            state_in = ukmm_pkg::S_REMOVE;
         end
         ukmm_pkg::S_REMOVE: begin
            state_in = ukmm_pkg::S_DONE;
         end
         ukmm_pkg::S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = ukmm_pkg::S_IDLE;
         end
         default: begin
            state_in = ukmm_pkg::S_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready  = 1'b0;
      cnt_in      = cnt_ff;
      tag_we      = 1'b0;
      tag_waddr   = cnt_ff[AW-1:0];
      tag_wdata   = '0;
      tag_re      = 1'b0;
      weight_we   = 1'b0;
      weight_re   = 1'b0;
      status_in   = ukmm_pkg::ST_EMPTY;
      status_load = 1'b0;
      rsp_load    = 1'b0;
      acc_ctl     = '0;
      acc_weight  = weight_ff;
      acc_cost    = cost_ff;
      scan_ctl.start       = 1'b0;
      scan_ctl.sample      = rd_vld_ff;
      scan_ctl.insert_mode = is_insert;
      scan_ctl.max_mode    = op_ff == ukmm_pkg::OP_REMOVE_MAX;
      case (state_ff)
         ukmm_pkg::S_CLEAR: begin
            tag_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
         ukmm_pkg::S_IDLE: begin
            req_tready     = 1'b1;
            scan_ctl.start = 1'b1;
            cnt_in         = '0;
         end
         ukmm_pkg::S_SCAN: begin
            tag_re = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
         ukmm_pkg::S_DECIDE: begin
            status_load = 1'b1;
            tag_waddr   = free_idx;
            tag_wdata   = {1'b1, cost_ff};
            if (is_insert) begin
               if (scan_flags.dup) begin
                  status_in = ukmm_pkg::ST_DUPLICATE;
               end else if (!scan_flags.free_found) begin
                  status_in = ukmm_pkg::ST_FULL;
               end else begin
                  status_in   = ukmm_pkg::ST_INSERTED;
                  tag_we      = 1'b1;
                  weight_we   = 1'b1;
                  acc_ctl.add = 1'b1;
               end
            end else if ((op_ff == ukmm_pkg::OP_REMOVE_MAX
                          || op_ff == ukmm_pkg::OP_REMOVE_MIN) && scan_flags.best_found) begin
               status_in = ukmm_pkg::ST_REMOVED;
               weight_re = 1'b1;
            end
         end
         ukmm_pkg::S_REMOVE: begin
            tag_we      = 1'b1;
            tag_waddr   = best_idx;
            tag_wdata   = '0;
            acc_ctl.sub = 1'b1;
            acc_weight  = weight_rd_ff;
            acc_cost    = best_cost;
         end
         ukmm_pkg::S_DONE: begin
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // state, counter and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ukmm_pkg::S_CLEAR;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= tag_re;
      end
      rd_idx_ff <= cnt_ff[AW-1:0];
      if (accept) begin
         op_ff     <= req_tdata[1:0];
         weight_ff <= req_tdata[21:2];
         cost_ff   <= req_tdata[41:22];
      end
      if (status_load) begin
         status_ff <= status_in;
      end
   end

   // tag memory: one write or one read a cycle
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      if (tag_re) begin
         tag_rd_ff <= tag_mem[cnt_ff[AW-1:0]];
      end
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[free_idx] <= weight_ff;
      end
      if (weight_re) begin
         weight_rd_ff <= weight_mem[best_idx];
      end
   end

   ukmm_scan_unit #(
      .AW (AW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .idx       (rd_idx_ff),
      .tag_valid (tag_rd_ff[TAG_W-1]),
      .tag_cost  (tag_rd_ff[ukmm_pkg::COST_W-1:0]),
      .key_cost  (cost_ff),
      .flags     (scan_flags),
      .free_idx  (free_idx),
      .best_idx  (best_idx),
      .best_cost (best_cost)
   );

   ukmm_accum #(
      .CW (CW)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acc_ctl),
      .weight     (acc_weight),
      .cost       (acc_cost),
      .weight_sum (weight_sum),
      .cost_sum   (cost_sum),
      .count      (count)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_tdata_ff <= {4'b0, ukmm_pkg::TOTAL_W'(count), cost_sum, weight_sum, status_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

// File: sv/ukmm_checker.sv
// Port-level checks for the unique key min/max table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ukmm_checker (
   input wire                              clock,
   input wire                              reset,
   input wire [ukmm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire [ukmm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // status codes stay in the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ukmm_pkg::ST_FULL)
      else $error("status out of range");

   // a successful insert leaves at least one entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ukmm_pkg::ST_INSERTED |-> rsp_tdata[67:59] != '0)
      else $error("insert reported with empty table");

   // the block is busy right after it takes an item
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

endmodule

bind unique_key_minmax_table ukmm_checker u_ukmm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

// File: tb/tb_unique_key_minmax_table.sv
// Self-checking testbench for the unique key min/max table with stream-side idling and backpressure.
`timescale 1ns / 1ps
module tb_unique_key_minmax_table;
   import ukmm_pkg::*;

   localparam int DEPTH        = 256;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = DEPTH + 64;
   // code outside the defined operations; the block must treat it as a no-op
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // one input item, op in the low bits as on req_tdata
   typedef struct packed {
      logic [COST_W-1:0]   cost;
      logic [WEIGHT_W-1:0] weight;
      logic [OP_W-1:0]     op;
   } table_op_t;

   // one result item, status in the low bits as on rsp_tdata
   typedef struct packed {
      logic [TOTAL_W-1:0]  entry_total;
      logic [SUM_W-1:0]    total_cost;
      logic [SUM_W-1:0]    total_weight;
      logic [STATUS_W-1:0] status;
   } table_rsp_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   unique_key_minmax_table #(
      .DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the table used for prediction
   logic                slot_used [DEPTH];
   logic [WEIGHT_W-1:0] slot_w    [DEPTH];
   logic [COST_W-1:0]   slot_c    [DEPTH];
   logic [TOTAL_W-1:0]  entries;
   logic [SUM_W-1:0]    weight_total;
   logic [SUM_W-1:0]    cost_total;
   int                  peak_entries;

   // stimulus bookkeeping
   table_op_t  pending_ops[$];
   table_rsp_t expected_rsps[$];
   logic [COST_W-1:0] fill_costs[$];
   bit   cost_live[int];
   int   queued_total   = 0;
   int   accepted_total = 0;
   int   results_seen   = 0;
   int   error_count    = 0;
   int   status_hits[8];
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   hold_asked     = 0;
   int   hold_served    = 0;
   int   hold_left      = 0;
   logic req_fire       = 1'b0;

   // apply one item to the shadow table and return the result it should produce
   function automatic table_rsp_t apply_table_op(table_op_t item);
      int                  i;
      int                  pick;
      int                  free_slot;
      logic [STATUS_W-1:0] st;
      table_rsp_t          r;
      pick      = -1;
      free_slot = -1;
      case (item.op)
         OP_INSERT: begin
            st = ST_INSERTED;
            for (i = 0; i < DEPTH; i++) begin
               if (slot_used[i]) begin
                  if (slot_c[i] == item.cost) st = ST_DUPLICATE;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            // duplicate check wins over the full check
            if (st == ST_INSERTED) begin
               if (free_slot < 0) begin
                  st = ST_FULL;
               end else begin
                  slot_used[free_slot] = 1'b1;
                  slot_w[free_slot]    = item.weight;
                  slot_c[free_slot]    = item.cost;
                  entries              = entries + 1'b1;
                  weight_total         = weight_total + item.weight;
                  cost_total           = cost_total + item.cost;
               end
            end
         end
         OP_REMOVE_MAX, OP_REMOVE_MIN: begin
            for (i = 0; i < DEPTH; i++) begin
               if (slot_used[i] && (pick < 0 ||
                   (item.op == OP_REMOVE_MAX && slot_c[i] > slot_c[pick]) ||
                   (item.op == OP_REMOVE_MIN && slot_c[i] < slot_c[pick])))
                  pick = i;
            end
            if (pick < 0) begin
               st = ST_EMPTY;
            end else begin
               slot_used[pick] = 1'b0;
               entries         = entries - 1'b1;
               weight_total    = weight_total - slot_w[pick];
               cost_total      = cost_total - slot_c[pick];
               st              = ST_REMOVED;
            end
         end
         default: st = ST_EMPTY;
      endcase
      if (int'(entries) > peak_entries) peak_entries = int'(entries);
      r.status       = st;
      r.total_weight = weight_total;
      r.total_cost   = cost_total;
      r.entry_total  = entries;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
   endtask

   // compare one result against the oldest expectation
   task automatic check_result(table_rsp_t got);
      table_rsp_t want;
      results_seen++;
      if (expected_rsps.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected (status %0d)", got.status));
         return;
      end
      want = expected_rsps.pop_front();
      status_hits[want.status]++;
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.total_weight !== want.total_weight)
         report_mismatch($sformatf("total_weight %0d, expected %0d",
                                   got.total_weight, want.total_weight));
      if (got.total_cost !== want.total_cost)
         report_mismatch($sformatf("total_cost %0d, expected %0d",
                                   got.total_cost, want.total_cost));
      if (got.entry_total !== want.entry_total)
         report_mismatch($sformatf("entry_total %0d, expected %0d",
                                   got.entry_total, want.entry_total));
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_rsps.push_back(apply_table_op(table_op_t'(req_tdata[$bits(table_op_t)-1:0])));
         accepted_total++;
      end
      if (!reset && rsp_tvalid && rsp_tready)
         check_result(table_rsp_t'(rsp_tdata[$bits(table_rsp_t)-1:0]));
   end

   // item driver: offers the next pending item, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= {{(REQ_DATA_W - $bits(table_op_t)){1'b0}}, pending_ops.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result acceptor: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic push_op(logic [OP_W-1:0] op, logic [WEIGHT_W-1:0] w, logic [COST_W-1:0] c);
      table_op_t item;
      item.op     = op;
      item.weight = w;
      item.cost   = c;
      pending_ops.push_back(item);
      queued_total++;
   endtask

   task automatic wait_accepted();
      while (accepted_total != queued_total) @(posedge clock);
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return WEIGHT_W'($urandom_range(0, 2**WEIGHT_W - 1));
      endcase
   endfunction

   // mostly full range; a small window makes repeated costs likely
   function automatic logic [COST_W-1:0] pick_cost();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return COST_W'($urandom_range(0, 63));
         default: return COST_W'($urandom_range(0, 2**COST_W - 1));
      endcase
   endfunction

   // a cost not handed out before
   function automatic logic [COST_W-1:0] fresh_cost();
      logic [COST_W-1:0] c;
      do c = COST_W'($urandom_range(0, 2**COST_W - 1)); while (cost_live.exists(c));
      cost_live[c] = 1'b1;
      fill_costs.push_back(c);
      return c;
   endfunction

   task automatic push_random_op(int insert_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
         // some inserts reuse a cost that is probably still stored
         if (fill_costs.size() > 0 && $urandom_range(0, 3) == 0)
            push_op(OP_INSERT, pick_weight(),
                    fill_costs[$urandom_range(0, fill_costs.size() - 1)]);
         else
            push_op(OP_INSERT, pick_weight(), pick_cost());
      end else if (roll >= 97) begin
         push_op(OP_UNUSED, pick_weight(), pick_cost());
      end else if (roll[0]) begin
         push_op(OP_REMOVE_MAX, pick_weight(), pick_cost());
      end else begin
         push_op(OP_REMOVE_MIN, pick_weight(), pick_cost());
      end
   endtask

   // reset, then the stimulus phases
   initial begin
      for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      for (int i = 0; i < 8; i++) status_hits[i] = 0;
      entries      = '0;
      weight_total = '0;
      cost_total   = '0;
      peak_entries = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, slot reuse, unused code
      push_op(OP_REMOVE_MAX, '1, '1);
      push_op(OP_REMOVE_MIN, '0, '0);
      push_op(OP_UNUSED, '1, '1);
      push_op(OP_INSERT, '0, '0);
      push_op(OP_INSERT, '1, '1);
      push_op(OP_INSERT, '1, '0);
      push_op(OP_INSERT, 20'h55555, 20'hAAAAA);
      push_op(OP_INSERT, 20'hAAAAA, 20'h55555);
      push_op(OP_UNUSED, '0, '0);
      push_op(OP_REMOVE_MAX, '0, '0);
      push_op(OP_REMOVE_MIN, '0, '0);
      push_op(OP_INSERT, 20'd1, '0);
      push_op(OP_INSERT, 20'd1, '1);
      push_op(OP_INSERT, 20'd9, 20'hAAAAA);
      push_op(OP_REMOVE_MIN, '0, '0);
      push_op(OP_REMOVE_MIN, '0, '0);
      push_op(OP_REMOVE_MAX, '0, '0);
      push_op(OP_REMOVE_MAX, '0, '0);
      push_op(OP_REMOVE_MAX, '0, '0);
      push_op(OP_REMOVE_MIN, '0, '0);
      wait_accepted();

      // fill the table to the top with a sparse sender, then overflow it
      send_idle_pct  = 83;
      recv_stall_pct = 0;
      while (fill_costs.size() < DEPTH) begin
         if (fill_costs.size() > 0 && $urandom_range(0, 9) == 0)
            push_op(OP_INSERT, pick_weight(),
                    fill_costs[$urandom_range(0, fill_costs.size() - 1)]);
         else
            push_op(OP_INSERT, pick_weight(), fresh_cost());
      end
      repeat (3) push_op(OP_INSERT, pick_weight(), fresh_cost());
      push_op(OP_INSERT, pick_weight(), fill_costs[0]);
      wait_accepted();

      // long receiver hold-off while the sender keeps offering
      send_idle_pct = 0;
      hold_asked++;
      push_op(OP_REMOVE_MAX, '0, '0);
      push_op(OP_INSERT, pick_weight(), fresh_cost());
      push_op(OP_INSERT, pick_weight(), fresh_cost());
      push_op(OP_REMOVE_MIN, '0, '0);
      push_op(OP_INSERT, pick_weight(), fill_costs[1]);
      push_op(OP_REMOVE_MAX, '0, '0);
      push_op(OP_REMOVE_MIN, '0, '0);
      push_op(OP_UNUSED, '1, '1);
      wait_accepted();

      // mixed traffic against a stalling receiver
      recv_stall_pct = 83;
      repeat (110) push_random_op(40);
      wait_accepted();

      // drain-heavy traffic with both sides idling
      send_idle_pct  = 37;
      recv_stall_pct = 37;
      repeat (130) push_random_op(10);
      wait_accepted();

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d inserted, %0d duplicate, %0d removed,",
               results_seen, status_hits[ST_INSERTED], status_hits[ST_DUPLICATE],
               status_hits[ST_REMOVED]);
      $display("  %0d empty or unused-code no-ops, %0d dropped when full; peak %0d of %0d",
               status_hits[ST_EMPTY], status_hits[ST_FULL], peak_entries, DEPTH);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Timeout: %0d of %0d items accepted, %0d results outstanding",
               accepted_total, queued_total, expected_rsps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
